FILE: hdl/sl_pkg.sv
`default_nettype none
package sl_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int LINE_BITS   = 16;
    localparam int KW_COUNT    = 15;
    localparam int MAX_RES     = 3;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LC_MAX  = '1;

    // token kinds
    localparam logic [5:0] K_WORD  = 6'd0;
    localparam logic [5:0] K_PUNCT = 6'd16;
    localparam logic [5:0] K_LE    = 6'd30;
    localparam logic [5:0] K_GE    = 6'd31;
    localparam logic [5:0] K_INT   = 6'd32;
    localparam logic [5:0] K_DEC   = 6'd33;
    localparam logic [5:0] K_STR   = 6'd34;
    localparam logic [5:0] K_CHR   = 6'd35;

    // error codes
    localparam logic [1:0] E_NONE  = 2'd0;
    localparam logic [1:0] E_DOT   = 2'd1;
    localparam logic [1:0] E_CHR   = 2'd2;
    localparam logic [1:0] E_WORD  = 2'd3;

    // characters of interest
    localparam logic [7:0] C_NL    = 8'h0A;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_DQ    = 8'h22;
    localparam logic [7:0] C_SQ    = 8'h27;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_0     = 8'h30;
    localparam logic [7:0] C_9     = 8'h39;

    // keywords, right-justified, UTF-8
    localparam logic [127:0] KW_TEXT [KW_COUNT] = '{
        {"BASE_DE_", "DONN\303\211ES"}, "CHARGE", "CR\303\211E", "ET", "FAUX",
        "FICHIER", "NUL", "OU", "RETOURNE", "SI", "SUPPRIME", "TROUVE",
        "UTILISE", "VRAI", "\303\211CRIT"
    };
    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd16, 5'd6, 5'd5, 5'd2, 5'd4, 5'd7, 5'd3, 5'd2, 5'd8, 5'd2,
        5'd8, 5'd6, 5'd7, 5'd4, 5'd6
    };

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_HELD, M_NUM, M_STR, M_CBODY, M_CCLOSE, M_DEAD
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic [1:0]             error_code;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   line_number;
        logic [LINE_BITS-1:0]   column;
        logic                   run_last;
    } t_out;

    typedef struct packed {
        t_out [MAX_RES-1:0] slot;
        logic [1:0]         cnt;
    } t_bundle;

    typedef struct packed {
        t_mode                  lex_mode;
        logic [7:0]             held_char;
        logic [KW_COUNT-1:0]    keyword_mask;
        logic                   dot_seen;
        logic [7:0]             prev_byte;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [OFFSET_BITS-1:0] token_start;
        logic [LINE_BITS-1:0]   line_count;
        logic [LINE_BITS-1:0]   column_count;
    } t_lex_state;

    localparam t_lex_state LEX_RESET = '{
        lex_mode:     M_IDLE,
        held_char:    8'd0,
        keyword_mask: '1,
        dot_seen:     1'b0,
        prev_byte:    8'd0,
        byte_offset:  '0,
        token_start:  '0,
        line_count:   LINE_BITS'(1),
        column_count: '0
    };

endpackage
`default_nettype wire

FILE: hdl/sl_step.sv
`default_nettype none
module sl_step
    import sl_pkg::*;
(
    input  t_lex_state i_state,
    input  t_in        i_item,
    output t_lex_state o_state,
    output t_bundle    o_bundle
);

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } t_pinfo;

    function automatic t_pinfo punct_info(input logic [7:0] c);
        t_pinfo r;
        r.hit = 1'b1;
        unique case (c)
            8'h22:   r.idx = 4'd0;
            8'h27:   r.idx = 4'd1;
            8'h28:   r.idx = 4'd2;
            8'h29:   r.idx = 4'd3;
            8'h2C:   r.idx = 4'd4;
            8'h2E:   r.idx = 4'd5;
            8'h3A:   r.idx = 4'd6;
            8'h3B:   r.idx = 4'd7;
            8'h3C:   r.idx = 4'd8;
            8'h3E:   r.idx = 4'd9;
            8'h5B:   r.idx = 4'd10;
            8'h5D:   r.idx = 4'd11;
            8'h7B:   r.idx = 4'd12;
            8'h7D:   r.idx = 4'd13;
            default: begin
                r.hit = 1'b0;
                r.idx = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= C_0) && (c <= C_9);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SP) || (c == C_NL) || (c == C_TAB);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v,
                                                       input logic [1:0] n);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, v} + (OFFSET_BITS+1)'(n);
        return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_lc(input logic [LINE_BITS-1:0] v,
                                                    input logic [1:0] n);
        logic [LINE_BITS:0] s;
        s = {1'b0, v} + (LINE_BITS+1)'(n);
        return s[LINE_BITS] ? LC_MAX : s[LINE_BITS-1:0];
    endfunction

    function automatic t_lex_state adv(input t_lex_state st, input logic [1:0] n);
        t_lex_state r;
        r              = st;
        r.byte_offset  = sat_off(st.byte_offset, n);
        r.column_count = sat_lc(st.column_count, n);
        return r;
    endfunction

    function automatic logic [7:0] kw_byte(input int k, input logic [3:0] i);
        logic [3:0] p;
        p = 4'(KW_LEN[k] - 5'd1) - i;
        return KW_TEXT[k][{p, 3'b000} +: 8];
    endfunction

    function automatic logic [KW_COUNT-1:0] narrow(input logic [KW_COUNT-1:0] m,
                                                   input logic [OFFSET_BITS-1:0] idx,
                                                   input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = m;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (idx >= OFFSET_BITS'(KW_LEN[k]) || kw_byte(k, idx[3:0]) != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [5:0] word_kind(input logic [KW_COUNT-1:0] m,
                                             input logic [OFFSET_BITS-1:0] len);
        logic [5:0] r;
        r = K_WORD;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (m[k] && len == OFFSET_BITS'(KW_LEN[k])) begin
                r = 6'(k + 1);
            end
        end
        return r;
    endfunction

    function automatic t_out mk(input logic [5:0] kind, input logic [1:0] err,
                                input logic [OFFSET_BITS-1:0] start,
                                input logic [OFFSET_BITS-1:0] len, input t_lex_state st);
        t_out r;
        r.token_kind   = kind;
        r.error_code   = err;
        r.start_offset = start;
        r.token_length = len;
        r.line_number  = st.line_count;
        r.column       = st.column_count;
        r.run_last     = 1'b0;
        return r;
    endfunction

    function automatic t_bundle push(input t_bundle bb, input t_out e);
        t_bundle r;
        r = bb;
        if (r.cnt != 2'd3) begin
            r.slot[r.cnt] = e;
            r.cnt         = r.cnt + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [5:0] held_kind(input logic [7:0] c);
        t_pinfo p;
        p = punct_info(c);
        return K_PUNCT + (p.hit ? 6'(p.idx) : 6'd0);
    endfunction

    always_comb begin
        t_lex_state s;
        t_bundle    bb;
        logic [7:0] b;
        logic       do_idle;
        t_pinfo     pi;
        logic [OFFSET_BITS-1:0] len;

        s       = i_state;
        bb      = '0;
        b       = i_item.in_byte;
        do_idle = 1'b0;
        pi      = punct_info(b);
        len     = s.byte_offset - s.token_start;

        unique case (s.lex_mode)
            M_IDLE: do_idle = 1'b1;
            M_WORD: begin
                if (is_space(b) || pi.hit) begin
                    bb = push(bb, mk(word_kind(s.keyword_mask, len), E_NONE,
                                     s.token_start, len, s));
                    s.lex_mode = M_IDLE;
                    do_idle    = 1'b1;
                end else begin
                    s.keyword_mask = narrow(s.keyword_mask, len, b);
                    s = adv(s, 2'd1);
                end
            end
            M_HELD: begin
                if ((s.held_char == C_LT || s.held_char == C_GT) && b == C_EQ) begin
                    bb = push(bb, mk((s.held_char == C_LT) ? K_LE : K_GE, E_NONE,
                                     s.byte_offset, OFFSET_BITS'(2), s));
                    s = adv(s, 2'd2);
                    s.lex_mode = M_IDLE;
                end else if (s.held_char == C_DOT && is_digit(b)) begin
                    s.token_start = s.byte_offset;
                    s.dot_seen    = 1'b1;
                    s = adv(s, 2'd2);
                    s.lex_mode = M_NUM;
                end else begin
                    bb = push(bb, mk(held_kind(s.held_char), E_NONE, s.byte_offset,
                                     OFFSET_BITS'(1), s));
                    s = adv(s, 2'd1);
                    s.lex_mode = M_IDLE;
                    do_idle    = 1'b1;
                end
            end
            M_NUM: begin
                if (is_digit(b)) begin
                    s = adv(s, 2'd1);
                end else if (b == C_DOT) begin
                    if (s.dot_seen) begin
                        bb = push(bb, mk(K_WORD, E_DOT, s.token_start, len, s));
                        s.lex_mode = M_DEAD;
                    end else begin
                        s.dot_seen = 1'b1;
                        s = adv(s, 2'd1);
                    end
                end else begin
                    bb = push(bb, mk(s.dot_seen ? K_DEC : K_INT, E_NONE,
                                     s.token_start, len, s));
                    s.lex_mode = M_IDLE;
                    do_idle    = 1'b1;
                end
            end
            M_STR: begin
                // escaped quote stays inside the string
                if (b == C_DQ && s.prev_byte != C_BSL) begin
                    s = adv(s, 2'd1);
                    bb = push(bb, mk(K_STR, E_NONE, s.token_start, len, s));
                    s.lex_mode = M_IDLE;
                end else begin
                    s = adv(s, 2'd1);
                end
            end
            M_CBODY: begin
                s = adv(s, 2'd1);
                s.lex_mode = M_CCLOSE;
            end
            M_CCLOSE: begin
                if (b == C_SQ) begin
                    s = adv(s, 2'd1);
                    bb = push(bb, mk(K_CHR, E_NONE, s.token_start, OFFSET_BITS'(1), s));
                    s.lex_mode = M_IDLE;
                end else begin
                    bb = push(bb, mk(K_WORD, E_CHR, s.token_start, OFFSET_BITS'(1), s));
                    s.lex_mode = M_DEAD;
                end
            end
            M_DEAD: ;
        endcase

        if (do_idle) begin
            if (b == C_NL) begin
                s.line_count   = sat_lc(s.line_count, 2'd1);
                s.column_count = '0;
                s = adv(s, 2'd1);
            end else if (is_space(b)) begin
                s = adv(s, 2'd1);
            end else if (pi.hit) begin
                if (b == C_LT || b == C_GT || b == C_DOT) begin
                    s.lex_mode    = M_HELD;
                    s.held_char   = b;
                    s.token_start = s.byte_offset;
                end else if (b == C_DQ) begin
                    s = adv(s, 2'd1);
                    s.token_start = s.byte_offset;
                    s.lex_mode    = M_STR;
                end else if (b == C_SQ) begin
                    s = adv(s, 2'd1);
                    s.token_start = s.byte_offset;
                    s.lex_mode    = M_CBODY;
                end else begin
                    bb = push(bb, mk(K_PUNCT + 6'(pi.idx), E_NONE, s.byte_offset,
                                     OFFSET_BITS'(1), s));
                    s = adv(s, 2'd1);
                end
            end else if (is_digit(b)) begin
                s.lex_mode    = M_NUM;
                s.token_start = s.byte_offset;
                s.dot_seen    = 1'b0;
                s = adv(s, 2'd1);
            end else begin
                s.lex_mode     = M_WORD;
                s.token_start  = s.byte_offset;
                s.keyword_mask = narrow('1, '0, b);
                s = adv(s, 2'd1);
            end
        end

        s.prev_byte = b;

        if (i_item.in_last) begin
            len = s.byte_offset - s.token_start;
            unique case (s.lex_mode)
                M_WORD:   bb = push(bb, mk(K_WORD, E_WORD, s.token_start, len, s));
                M_HELD:   bb = push(bb, mk(held_kind(s.held_char), E_NONE, s.byte_offset,
                                           OFFSET_BITS'(1), s));
                M_NUM:    bb = push(bb, mk(s.dot_seen ? K_DEC : K_INT, E_NONE,
                                           s.token_start, len, s));
                M_STR:    bb = push(bb, mk(K_STR, E_NONE, s.token_start, len, s));
                M_CBODY:  bb = push(bb, mk(K_WORD, E_CHR, s.token_start, '0, s));
                M_CCLOSE: bb = push(bb, mk(K_WORD, E_CHR, s.token_start,
                                           OFFSET_BITS'(1), s));
                M_IDLE, M_DEAD: ;
            endcase
            s = LEX_RESET;
        end

        if (bb.cnt != 2'd0) begin
            bb.slot[2'(bb.cnt - 2'd1)].run_last = 1'b1;
        end

        o_state  = s;
        o_bundle = bb;
    end

endmodule
`default_nettype wire

FILE: hdl/sl_outq.sv
`default_nettype none
module sl_outq
    import sl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    output logic    o_can_load,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);

    t_bundle    r_bundle;
    logic       r_busy;
    logic [1:0] r_rd;
    logic       last_taken;

    assign last_taken  = r_busy && !i_out_stall && (r_rd == 2'(r_bundle.cnt - 2'd1));
    assign o_can_load  = !r_busy || last_taken;
    assign o_out_valid = r_busy;
    assign o_out_data  = r_bundle.slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd   <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_rd   <= 2'd0;
        end else if (last_taken) begin
            r_busy <= 1'b0;
        end else if (r_busy && !i_out_stall) begin
            r_rd <= r_rd + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/script_lexer.sv
`default_nettype none
// Streaming lexer: one source byte per input beat, in_last on the final byte of a
// script. Each byte is registered, then one pass of logic against the lexer state
// (mode, held mark, keyword mask, counters) yields up to three token records and
// the next state. Records are parked in a three-slot result register and leave one
// per cycle unless the output stalls. Throughput is one byte per cycle while each
// byte yields at most one record and the output does not stall; more records hold
// the input until the result register drains. A beat passes the input register,
// then the result register, before its first record. After the final byte any open
// token is closed and the state returns to its reset value for the next script.
module script_lexer
    import sl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // input register
    logic       r_iv;
    t_in        r_item;

    // lexer state
    t_lex_state r_state;
    t_lex_state n_state;
    t_bundle    n_bundle;

    logic can_load;
    logic step;

    // the registered byte is consumed once the result register can take its records
    assign step       = r_iv && can_load;
    assign o_in_stall = r_iv && !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_iv <= 1'b1;
        end else if (step) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    sl_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_bundle (n_bundle)
    );

    // bytes that yield no record never load the result register
    sl_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && (n_bundle.cnt != 2'd0)),
        .i_bundle    (n_bundle),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
